FILE: sv/bfa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfa_pkg
// Shared types and codes for the bitmap first-fit allocator.
// ----------------------------------------------------------------------------
package bfa_pkg;

  localparam int WORD_W      = 32;
  localparam int RESULT_CAP  = 12;

  // Input selector codes
  typedef enum logic [1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_ALLOC = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_EMPTY  = 2'd1,
    STAT_OVER   = 2'd2,
    STAT_NOFREE = 2'd3
  } status_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_BITS_IN_USE = 2'd0,
    CFG_BASE_OFFSET = 2'd1,
    CFG_SKIP_FIRST  = 2'd2,
    CFG_UNUSED      = 2'd3
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD_OUT,
    ST_STAT_OUT,
    ST_FETCH,
    ST_LOAD,
    ST_PICK,
    ST_CM_RD,
    ST_CM_WR,
    ST_EMIT
  } state_t;

  // Lowest-set-bit pick on one map word
  typedef struct packed {
    logic              hit;
    logic [4:0]        pos;
    logic [WORD_W-1:0] rest;
  } pick_t;

endpackage : bfa_pkg
`default_nettype wire

FILE: sv/bfa_pick.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfa_pick
// Find the lowest set bit of a candidate word and return the word without it.
// ----------------------------------------------------------------------------
module bfa_pick
  import bfa_pkg::*;
(
  input  wire logic [WORD_W-1:0] cand,
  output pick_t                  res
);

  logic [4:0] pos;

  always_comb begin
    pos = 5'd0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (cand[i]) begin
        pos = 5'(i);
      end
    end
  end

  assign res.hit  = |cand;
  assign res.pos  = pos;
  assign res.rest = cand & (cand - WORD_W'(1));

endmodule : bfa_pick
`default_nettype wire

FILE: sv/bitmap_first_fit_allocator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bitmap_first_fit_allocator
// Free map of one bit per block in a single-port-read, single-port-write
// synchronous RAM; load, read back and first-fit multi-block allocate.
// ----------------------------------------------------------------------------
// Sequencing: a load writes the map on acceptance, with no result; a read,
//   empty or oversize request passes through ST_RD_OUT or ST_STAT_OUT into
//   the output register. Allocate scans each map word through ST_FETCH,
//   ST_LOAD and ST_PICK, writes each grant back through ST_CM_RD and
//   ST_CM_WR, then emits a result per grant. One transaction at a time.
// Reset: map cleared one word a cycle, s_axis_tready low; cfg regs at once.
// ----------------------------------------------------------------------------
module bitmap_first_fit_allocator
  import bfa_pkg::*;
#(
  parameter int MAP_BITS        = 32768,
  parameter int MAX_PER_REQUEST = 12
) (
  input  wire logic        clk,
  input  wire logic        rst,

  // Input transactions
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  // [9:0] word_index, [41:10] word_data, [45:42] block_count, [47:46] zero
  input  wire logic [47:0] s_axis_tdata,
  // [1:0] func
  input  wire logic [1:0]  s_axis_tuser,

  // Result transactions
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [31:0] block_number, [63:32] read_data
  output      logic [63:0] m_axis_tdata,
  // [1:0] status
  output      logic [1:0]  m_axis_tuser,
  output      logic        m_axis_tlast,

  // Configuration writes
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  localparam int MAP_WORDS = (MAP_BITS + 31) / 32;
  localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int LW        = AW + 6;                // entry count width
  localparam int GW        = AW + 5;                // entry index width
  localparam int CAP       = (MAX_PER_REQUEST < RESULT_CAP) ? MAX_PER_REQUEST
                                                            : RESULT_CAP;
  localparam int FW        = $clog2(CAP + 1);
  localparam int GIW       = (CAP > 1) ? $clog2(CAP) : 1;

  // --------------------------------------------------------------------------
  // Input field unpacking
  // --------------------------------------------------------------------------
  logic [9:0]        in_word_index;
  logic [WORD_W-1:0] in_word_data;
  logic [3:0]        in_block_count;
  func_t             in_func;
  logic              in_range;
  logic [AW-1:0]     in_addr;

  assign in_word_index  = s_axis_tdata[9:0];
  assign in_word_data   = s_axis_tdata[41:10];
  assign in_block_count = s_axis_tdata[45:42];
  assign in_func        = func_t'(s_axis_tuser);
  assign in_range       = {22'd0, in_word_index} < 32'(MAP_WORDS);
  assign in_addr        = AW'(in_word_index);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [15:0] bits_in_use;
  logic [31:0] base_offset;
  logic        skip_first;

  always_ff @(posedge clk) begin
    if (rst) begin
      bits_in_use <= 16'd32768;
      base_offset <= 32'd0;
      skip_first  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_BITS_IN_USE: bits_in_use <= cfg_data[15:0];
        CFG_BASE_OFFSET: base_offset <= cfg_data;
        CFG_SKIP_FIRST:  skip_first  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Allocation limit, clamped to the map size
  logic [31:0] lim32;
  assign lim32 = ({16'd0, bits_in_use} >= 32'(MAP_BITS)) ? 32'(MAP_BITS)
                                                         : {16'd0, bits_in_use};

  // --------------------------------------------------------------------------
  // Free map RAM: one write and one registered read per cycle
  // --------------------------------------------------------------------------
  logic [WORD_W-1:0] map_mem [MAP_WORDS];
  logic [WORD_W-1:0] mem_q;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      map_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_q <= map_mem[mem_raddr];
    end
  end

  // --------------------------------------------------------------------------
  // Control and working registers
  // --------------------------------------------------------------------------
  state_t            state;
  state_t            state_next;
  logic [AW-1:0]     clr;
  logic [AW:0]       w;           // word under scan
  logic [LW-1:0]     limit;
  logic [3:0]        want;
  logic [FW-1:0]     found;
  logic [FW-1:0]     k;
  logic [WORD_W-1:0] cur;         // free candidates left in the scanned word
  logic [GW-1:0]     grant [CAP];
  status_t           stat;
  logic              rd_ok;

  // Output register
  logic              out_valid;
  logic              out_load;
  status_t           out_status_next;
  logic [31:0]       out_block_next;
  logic [WORD_W-1:0] out_rdata_next;
  logic              out_last_next;
  status_t           out_status;
  logic [31:0]       out_block;
  logic [WORD_W-1:0] out_rdata;
  logic              out_last;
  logic              out_free;

  assign out_free = !out_valid || m_axis_tready;

  // --------------------------------------------------------------------------
  // Scan helpers
  // --------------------------------------------------------------------------
  logic [AW:0]       lim_word;
  logic [4:0]        lim_bit;
  logic [WORD_W-1:0] scan_mask;
  logic              scan_end;
  pick_t             pick;
  logic [GW-1:0]     cm_grant;
  logic [FW-1:0]     k_inc;
  logic              k_last;

  assign lim_word = limit[LW-1:5];
  assign lim_bit  = limit[4:0];
  assign scan_end = {w, 5'd0} >= limit;
  assign cm_grant = grant[k[GIW-1:0]];
  assign k_inc    = k + FW'(1);
  assign k_last   = k_inc == found;

  // Entries of word w that may be handed out
  always_comb begin
    if (w < lim_word) begin
      scan_mask = '1;
    end else if (w == lim_word) begin
      scan_mask = (WORD_W'(1) << lim_bit) - WORD_W'(1);
    end else begin
      scan_mask = '0;
    end
    if (skip_first && (w == '0)) begin
      scan_mask[0] = 1'b0;
    end
  end

  bfa_pick u_pick (
    .cand (cur),
    .res  (pick)
  );

  // --------------------------------------------------------------------------
  // Next state, RAM controls and output loads
  // --------------------------------------------------------------------------
  always_comb begin
    state_next      = state;
    mem_we          = 1'b0;
    mem_waddr       = clr;
    mem_wdata       = '0;
    mem_re          = 1'b0;
    mem_raddr       = in_addr;
    out_load        = 1'b0;
    out_status_next = STAT_OK;
    out_block_next  = '0;
    out_rdata_next  = '0;
    out_last_next   = 1'b1;
    s_axis_tready   = 1'b0;

    unique case (state)
      ST_CLEAR: begin
        // Zero one map word per cycle
        mem_we = 1'b1;
        if (clr == AW'(MAP_WORDS - 1)) begin
          state_next = ST_IDLE;
        end
      end

      ST_IDLE: begin
        // Ready is high here, so valid alone marks an accepted transaction
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          unique case (in_func)
            FUNC_LOAD: begin
              mem_we    = in_range;
              mem_waddr = in_addr;
              mem_wdata = in_word_data;
            end
            FUNC_READ: begin
              mem_re     = 1'b1;
              state_next = ST_RD_OUT;
            end
            FUNC_ALLOC: begin
              if ((in_block_count == 4'd0) || (in_block_count > 4'(CAP))) begin
                state_next = ST_STAT_OUT;
              end else begin
                state_next = ST_FETCH;
              end
            end
            default: ;
          endcase
        end
      end

      ST_RD_OUT: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_rdata_next = rd_ok ? mem_q : '0;
          state_next     = ST_IDLE;
        end
      end

      ST_STAT_OUT: begin
        if (out_free) begin
          out_load        = 1'b1;
          out_status_next = stat;
          state_next      = ST_IDLE;
        end
      end

      ST_FETCH: begin
        // Past the limit without enough free entries: reject
        if (scan_end) begin
          state_next = ST_STAT_OUT;
        end else begin
          mem_re     = 1'b1;
          mem_raddr  = w[AW-1:0];
          state_next = ST_LOAD;
        end
      end

      ST_LOAD: begin
        state_next = ST_PICK;
      end

      ST_PICK: begin
        if (4'(found) == want) begin
          state_next = ST_CM_RD;
        end else if (!pick.hit) begin
          state_next = ST_FETCH;
        end
      end

      ST_CM_RD: begin
        mem_re     = 1'b1;
        mem_raddr  = cm_grant[GW-1:5];
        state_next = ST_CM_WR;
      end

      ST_CM_WR: begin
        // Read of the next grant starts only after this write lands
        mem_we    = 1'b1;
        mem_waddr = cm_grant[GW-1:5];
        mem_wdata = mem_q | (WORD_W'(1) << cm_grant[4:0]);
        if (k_last) begin
          state_next = ST_EMIT;
        end else begin
          state_next = ST_CM_RD;
        end
      end

      ST_EMIT: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_block_next = base_offset + 32'(cm_grant);
          out_last_next  = k_last;
          if (k_last) begin
            state_next = ST_IDLE;
          end
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // --------------------------------------------------------------------------
  // Working register updates
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      clr <= '0;
    end else if (state == ST_CLEAR) begin
      clr <= clr + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        rd_ok <= in_range;
        want  <= in_block_count;
        limit <= LW'(lim32);
        w     <= '0;
        found <= '0;
        k     <= '0;
        if (in_block_count == 4'd0) begin
          stat <= STAT_EMPTY;
        end else if (in_block_count > 4'(CAP)) begin
          stat <= STAT_OVER;
        end else begin
          stat <= STAT_NOFREE;
        end
      end

      ST_LOAD: begin
        cur <= ~mem_q & scan_mask;
      end

      ST_PICK: begin
        if (4'(found) != want) begin
          if (pick.hit) begin
            grant[found[GIW-1:0]] <= {w[AW-1:0], pick.pos};
            found                 <= found + FW'(1);
            cur                   <= pick.rest;
          end else begin
            w <= w + (AW + 1)'(1);
          end
        end
      end

      ST_CM_WR: begin
        k <= k_last ? '0 : k_inc;
      end

      ST_EMIT: begin
        if (out_free) begin
          k <= k_inc;
        end
      end

      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Output register: hold until the downstream side takes it
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status <= out_status_next;
      out_block  <= out_block_next;
      out_rdata  <= out_rdata_next;
      out_last   <= out_last_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_rdata, out_block};
  assign m_axis_tuser  = out_status;
  assign m_axis_tlast  = out_last;

endmodule : bitmap_first_fit_allocator
`default_nettype wire

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bitmap first-fit allocator. It walks a short
// table of directed accesses and then random bursts under several register
// settings and stall patterns. Every result is checked against a typed-in
// value or a cycle-free model of the free map kept in the bench.
// ----------------------------------------------------------------------------
module tb_top;
  import bfa_pkg::*;

  localparam int          MAP_WORDS     = 1024;
  localparam int          MAP_LIMIT     = 32768;
  localparam int          PER_REQ_CAP   = RESULT_CAP;
  localparam int          SETTLE_CYCLES = 16;
  localparam int          TAIL_CYCLES   = 50;
  localparam int          BURST_ITEMS   = 29;
  localparam int unsigned CYCLE_LIMIT   = 5000000;

  // One result transaction as seen on the master side.
  typedef struct packed {
    status_t     status;
    logic [31:0] block_number;
    logic [31:0] read_data;
    logic        last;
  } result_t;

  // One row of stimulus: either an access or a new register setting.
  typedef struct packed {
    logic        is_setting;
    func_t       func;
    logic [9:0]  word_index;
    logic [31:0] word_data;
    logic [3:0]  block_count;
    logic        checked;
    status_t     status;
    logic [31:0] block_number;
    logic [31:0] read_data;
    logic [15:0] bits;
    logic [31:0] base;
    logic        skip;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  // Shadow copy of the block's state and registers.
  logic [31:0] shadow_map [0:MAP_WORDS-1];
  int unsigned shadow_bits;
  logic [31:0] shadow_base;
  logic        shadow_skip;

  result_t     fresh_results[$];  // results of the access just predicted
  result_t     due_results[$];    // results still owed by the block
  plan_row_t   plan[$];

  int unsigned send_gap_pct;
  int unsigned take_gap_pct;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;

  bitmap_first_fit_allocator dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #1 clk = ~clk;

  function automatic result_t make_result(status_t st, logic [31:0] blk,
                                          logic [31:0] rd, logic last);
    result_t r;
    r.status       = st;
    r.block_number = blk;
    r.read_data    = rd;
    r.last         = last;
    return r;
  endfunction

  function automatic plan_row_t op_row(func_t f, logic [9:0] idx, logic [31:0] data,
                                       logic [3:0] cnt);
    plan_row_t r;
    r             = '0;
    r.func        = f;
    r.word_index  = idx;
    r.word_data   = data;
    r.block_count = cnt;
    return r;
  endfunction

  // Pin the expected single result of a row to a value typed in by hand.
  function automatic plan_row_t with_expect(plan_row_t r, status_t st, logic [31:0] blk,
                                            logic [31:0] rd);
    r.checked      = 1'b1;
    r.status       = st;
    r.block_number = blk;
    r.read_data    = rd;
    return r;
  endfunction

  function automatic plan_row_t setting_row(logic [15:0] bits, logic [31:0] base,
                                            logic skip);
    plan_row_t r;
    r            = '0;
    r.is_setting = 1'b1;
    r.bits       = bits;
    r.base       = base;
    r.skip       = skip;
    return r;
  endfunction

  // Work out what one access does to the map and which results it owes.
  function automatic void predict_access(func_t f, logic [9:0] widx, logic [31:0] wdat,
                                         logic [3:0] want);
    int unsigned lim;
    int unsigned e;
    int unsigned grant[$];
    fresh_results.delete();
    case (f)
      FUNC_LOAD: shadow_map[widx] = wdat;
      FUNC_READ: fresh_results.push_back(make_result(STAT_OK, '0, shadow_map[widx], 1'b1));
      FUNC_ALLOC: begin
        if (want == 0) begin
          fresh_results.push_back(make_result(STAT_EMPTY, '0, '0, 1'b1));
        end else if (want > PER_REQ_CAP) begin
          fresh_results.push_back(make_result(STAT_OVER, '0, '0, 1'b1));
        end else begin
          lim = (shadow_bits > MAP_LIMIT) ? MAP_LIMIT : shadow_bits;
          e   = shadow_skip ? 1 : 0;
          while (e < lim && grant.size() < want) begin
            if (!shadow_map[e / 32][e % 32]) grant.push_back(e);
            e++;
          end
          if (grant.size() < want) begin
            // Short of free entries: reject and leave the map untouched.
            fresh_results.push_back(make_result(STAT_NOFREE, '0, '0, 1'b1));
          end else begin
            foreach (grant[i]) begin
              shadow_map[grant[i] / 32][grant[i] % 32] = 1'b1;
              fresh_results.push_back(make_result(STAT_OK, shadow_base + grant[i], '0,
                                                  i == grant.size() - 1));
            end
          end
        end
      end
      default: ;
    endcase
  endfunction

  // Present one access, hold it until the block takes it, then book its results.
  task automatic send_access(plan_row_t r);
    while ($urandom_range(99) < send_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, r.block_count, r.word_data, r.word_index};
    s_axis_tuser  <= r.func;
    do @(posedge clk); while (!s_axis_tready);
    predict_access(r.func, r.word_index, r.word_data, r.block_count);
    if (r.checked) begin
      due_results.push_back(make_result(r.status, r.block_number, r.read_data, 1'b1));
    end else begin
      foreach (fresh_results[i]) due_results.push_back(fresh_results[i]);
    end
  endtask

  // Drop valid and let the block drain before touching the registers.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write every register once; the unused index is hit too and must be ignored.
  task automatic apply_settings(logic [15:0] bits, logic [31:0] base, logic skip);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_UNUSED;
    cfg_data  <= $urandom;
    @(posedge clk);
    cfg_index <= CFG_BITS_IN_USE;
    cfg_data  <= {16'($urandom), bits};
    @(posedge clk);
    cfg_index <= CFG_BASE_OFFSET;
    cfg_data  <= base;
    @(posedge clk);
    cfg_index <= CFG_SKIP_FIRST;
    cfg_data  <= {31'($urandom), skip};
    @(posedge clk);
    cfg_we      <= 1'b0;
    shadow_bits  = bits;
    shadow_base  = base;
    shadow_skip  = skip;
  endtask

  // Random traffic. Keep most loads and reads on the low words that the
  // first-fit scan actually walks, so the map fills up and rejects happen.
  task automatic random_burst(int unsigned count);
    int unsigned done;
    int unsigned pick;
    int unsigned hot;
    logic [9:0]  idx;
    logic [31:0] data;
    logic [3:0]  cnt;
    done = 0;
    while (done < count) begin
      hot = ((shadow_bits > MAP_LIMIT ? MAP_LIMIT : shadow_bits) + 31) / 32;
      if (hot > 8) hot = 8;
      if (hot == 0) hot = 1;
      idx = ($urandom_range(99) < 70) ? 10'($urandom_range(hot - 1))
                                      : 10'($urandom_range(MAP_WORDS - 1));
      case ($urandom_range(3))
        0: data = 32'd0;
        1: data = 32'hFFFF_FFFF;
        2: data = $urandom & $urandom;
        default: data = $urandom;
      endcase
      cnt  = ($urandom_range(99) < 85) ? 4'($urandom_range(PER_REQ_CAP, 1))
                                       : 4'($urandom_range(15));
      pick = $urandom_range(99);
      if (pick < 4) begin
        // Unused selector: ignored by the block, not counted.
        send_access(op_row(FUNC_NONE, 10'($urandom), $urandom, 4'($urandom)));
      end else begin
        if (pick < 26) send_access(op_row(FUNC_LOAD, idx, data, cnt));
        else if (pick < 42) send_access(op_row(FUNC_READ, idx, data, cnt));
        else send_access(op_row(FUNC_ALLOC, idx, data, cnt));
        done++;
      end
    end
  endtask

  // Master side: check each result transaction against the oldest one owed,
  // and stall the block at random.
  always @(posedge clk) begin : take_result
    result_t got;
    result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = make_result(status_t'(m_axis_tuser), m_axis_tdata[31:0], m_axis_tdata[63:32],
                        m_axis_tlast);
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] unexpected result: status %0d block %h read %h last %b",
                   $realtime, got.status, got.block_number, got.read_data, got.last);
      end else begin
        want = due_results.pop_front();
        if (got.status !== want.status || got.block_number !== want.block_number ||
            got.read_data !== want.read_data || got.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] result mismatch: expected status %0d block %h read %h last %b, %s",
                     $realtime, want.status, want.block_number, want.read_data, want.last,
                     $sformatf("got status %0d block %h read %h last %b", got.status,
                               got.block_number, got.read_data, got.last));
        end
      end
    end
    m_axis_tready <= ($urandom_range(99) >= take_gap_pct);
  end

  // Watchdog: a hung handshake or a missing result ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("bitmap_first_fit_allocator verification failed");
      $finish;
    end
  end

  initial begin
    // Drive every input to a known value before the first edge.
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = FUNC_NONE;
    m_axis_tready = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_UNUSED;
    cfg_data      = '0;
    foreach (shadow_map[i]) shadow_map[i] = '0;
    shadow_bits  = MAP_LIMIT;
    shadow_base  = '0;
    shadow_skip  = 1'b0;
    send_gap_pct = 23;
    take_gap_pct = 50;

    // Directed table. Rows with a typed-in result are checked against that
    // value; the rest go through the predictor.
    // Fresh map after reset: empty reads, request-size errors, first grant.
    plan.push_back(with_expect(op_row(FUNC_READ, 10'd0, 32'd0, 4'd0), STAT_OK, 0, 0));
    plan.push_back(with_expect(op_row(FUNC_READ, 10'd1023, 32'd0, 4'd0), STAT_OK, 0, 0));
    plan.push_back(with_expect(op_row(FUNC_ALLOC, 10'd0, 32'd0, 4'd0), STAT_EMPTY, 0, 0));
    plan.push_back(with_expect(op_row(FUNC_ALLOC, 10'd0, 32'd0, 4'd13), STAT_OVER, 0, 0));
    plan.push_back(with_expect(op_row(FUNC_ALLOC, 10'd0, 32'd0, 4'd15), STAT_OVER, 0, 0));
    plan.push_back(with_expect(op_row(FUNC_ALLOC, 10'd0, 32'd0, 4'd1), STAT_OK, 0, 0));
    plan.push_back(op_row(FUNC_ALLOC, 10'd0, 32'd0, 4'd12));
    plan.push_back(with_expect(op_row(FUNC_READ, 10'd0, 32'd0, 4'd0), STAT_OK, 0,
                               32'h0000_1FFF));
    // Loads at both ends of the map, then a grant that hops over used bits.
    plan.push_back(op_row(FUNC_LOAD, 10'd0, 32'hFFFF_FFFF, 4'd0));
    plan.push_back(op_row(FUNC_LOAD, 10'd1023, 32'hFFFF_FFFF, 4'd0));
    plan.push_back(op_row(FUNC_LOAD, 10'd1, 32'hAAAA_AAAA, 4'd0));
    plan.push_back(op_row(FUNC_ALLOC, 10'd0, 32'd0, 4'd3));
    plan.push_back(op_row(FUNC_NONE, 10'h3FF, 32'hFFFF_FFFF, 4'hF));
    plan.push_back(with_expect(op_row(FUNC_READ, 10'd1023, 32'd0, 4'd0), STAT_OK, 0,
                               32'hFFFF_FFFF));
    plan.push_back(op_row(FUNC_LOAD, 10'd1023, 32'd0, 4'd0));
    // Tight limit, entry zero held back, block numbers wrapping past 2^32.
    plan.push_back(setting_row(16'd40, 32'hFFFF_FFFE, 1'b1));
    plan.push_back(op_row(FUNC_LOAD, 10'd0, 32'd0, 4'd0));
    plan.push_back(op_row(FUNC_ALLOC, 10'd0, 32'd0, 4'd12));
    plan.push_back(op_row(FUNC_ALLOC, 10'd0, 32'd0, 4'd12));
    plan.push_back(op_row(FUNC_ALLOC, 10'd0, 32'd0, 4'd12));
    // Zero limit: nothing can be granted, but an empty request is still empty.
    plan.push_back(setting_row(16'd0, 32'd0, 1'b0));
    plan.push_back(with_expect(op_row(FUNC_ALLOC, 10'd0, 32'd0, 4'd1), STAT_NOFREE, 0, 0));
    plan.push_back(with_expect(op_row(FUNC_ALLOC, 10'd0, 32'd0, 4'd0), STAT_EMPTY, 0, 0));
    // Limit above the map size acts as the map size.
    plan.push_back(setting_row(16'hFFFF, 32'h1234_5678, 1'b1));
    plan.push_back(op_row(FUNC_LOAD, 10'd0, 32'd0, 4'd0));
    plan.push_back(with_expect(op_row(FUNC_ALLOC, 10'd0, 32'd0, 4'd1), STAT_OK,
                               32'h1234_5679, 0));
    plan.push_back(with_expect(op_row(FUNC_READ, 10'd0, 32'd0, 4'd0), STAT_OK, 0,
                               32'h0000_0002));
    plan.push_back(op_row(FUNC_ALLOC, 10'd0, 32'd0, 4'd12));

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // The block clears its map after reset with tready low; the first
    // transaction simply waits for it.
    foreach (plan[i]) begin
      if (plan[i].is_setting) begin
        settle();
        apply_settings(plan[i].bits, plan[i].base, plan[i].skip);
      end else begin
        send_access(plan[i]);
      end
    end

    // Random part: sender idles less than receiver, then the reverse, then
    // full speed. Two register settings in each stall pattern.
    settle();
    apply_settings(16'd200, $urandom, 1'b1);
    random_burst(BURST_ITEMS);
    settle();
    apply_settings(16'd64, 32'd0, 1'b0);
    random_burst(BURST_ITEMS);

    send_gap_pct = 50;
    take_gap_pct = 23;
    settle();
    apply_settings(16'hFFFF, 32'hFFFF_FFF0, 1'b0);
    random_burst(BURST_ITEMS);
    settle();
    apply_settings(16'd37, $urandom, 1'b1);
    random_burst(BURST_ITEMS);

    send_gap_pct = 0;
    take_gap_pct = 0;
    settle();
    apply_settings(16'd32768, 32'hFFFF_FFFF, 1'b1);
    random_burst(BURST_ITEMS);
    settle();
    apply_settings(16'd1000, $urandom, 1'b0);
    random_burst(BURST_ITEMS);

    // Wait out every owed result, then a quiet tail to catch strays.
    s_axis_tvalid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("bitmap_first_fit_allocator verification clean");
    end else begin
      $display("bitmap_first_fit_allocator verification failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/bfa_pkg.sv
sv/bfa_pick.sv
sv/bitmap_first_fit_allocator.sv
test/tb_top.sv
